### hdl/normal_cdf_approximation_defines.svh
// Assertion macros shared by the normal CDF block.
`ifndef NORMAL_CDF_APPROXIMATION_DEFINES_SVH
`define NORMAL_CDF_APPROXIMATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NCDF_CHECK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NCDF_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ncdf_pkg.sv
// Types and constants of the normal CDF pipeline.
package ncdf_pkg;

    // Control that travels with every beat through the pipeline.
    typedef struct packed {
        logic v;
        logic neg;
        logic zero;
    } t_side;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STD_DEV = 1'b1;
    localparam logic [30:0] STD_DEV_RESET = 31'd65536;

    // z is unsigned Q3.32.
    localparam int Z_INT_BITS  = 3;
    localparam int Z_FRAC_BITS = 32;
    localparam int Z_W         = Z_INT_BITS + Z_FRAC_BITS;
    localparam int K_W         = 5;

    // Exponent data carried from the ratio divider to the final multiply.
    typedef struct packed {
        logic [K_W-1:0] k;
        logic [31:0]    f;
        logic [31:0]    ratio;
    } t_exp_arg;

    localparam logic [36:0] TAIL_LIMIT  = 37'd25 << 32;
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [31:0] EXP_M1_Q32  = 32'd1580030169;
    localparam logic [31:0] PROB_ONE    = 32'h8000_0000;

    localparam int SERIES_TERMS = 13;
    localparam int POW_STAGES   = 24;
    localparam int RATIO_BITS   = 32;
    localparam int HORNER_STEPS = 7;

    // Rational approximation coefficients in units of 1e-12.
    localparam logic [63:0] NUM_COEF [0:6] = '{
        64'd220206867912376, 64'd221213596169931, 64'd112079291497871,
        64'd33912866078383, 64'd6373962203532, 64'd700383064444, 64'd35262496600
    };
    localparam logic [63:0] DEN_COEF [0:7] = '{
        64'd440413735824752, 64'd793826512519948, 64'd637333633378831,
        64'd296564248779674, 64'd86780732202946, 64'd16064177579207,
        64'd1755667163183, 64'd88388347648
    };

    // floor(2^33 / i), used to divide the series terms by i.
    localparam logic [33:0] SER_RECIP [1:SERIES_TERMS] = '{
        34'((64'd1 << 33) / 64'd1),  34'((64'd1 << 33) / 64'd2),
        34'((64'd1 << 33) / 64'd3),  34'((64'd1 << 33) / 64'd4),
        34'((64'd1 << 33) / 64'd5),  34'((64'd1 << 33) / 64'd6),
        34'((64'd1 << 33) / 64'd7),  34'((64'd1 << 33) / 64'd8),
        34'((64'd1 << 33) / 64'd9),  34'((64'd1 << 33) / 64'd10),
        34'((64'd1 << 33) / 64'd11), 34'((64'd1 << 33) / 64'd12),
        34'((64'd1 << 33) / 64'd13)
    };

endpackage

### hdl/normal_cdf_approximation.sv
// Normal CDF of a Q16.16 sample for a configured mean and standard deviation.
//
// The block takes one sample on every clock edge at which start is high; busy
// never rises. Each result comes out on o_probability with o_valid high for one
// cycle, in order. The pipeline holds the front stages, a 35-stage restoring
// divider for z, the squaring stages, a 14-stage pair of Horner polynomials, a
// 32-stage ratio divider, 39 stages of the exponential series, 24 stages of
// powers of exp(-1) and the output stages.
// Write mean and std_dev only while no sample is in flight. A zero std_dev
// gives 0 at or below the mean and 1.0 above it.

`include "normal_cdf_approximation_defines.svh"

module normal_cdf_approximation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    i_sample,
    output logic                           o_valid,
    output logic [31:0]                    o_probability,
    input  logic                           i_cfg_we,
    input  logic [ncdf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data
);

    localparam int ZW = ncdf_pkg::Z_W;
    localparam int KW = ncdf_pkg::K_W;
    localparam int HS = ncdf_pkg::HORNER_STEPS;
    localparam int RB = ncdf_pkg::RATIO_BITS;
    localparam int ST = ncdf_pkg::SERIES_TERMS;
    localparam int PS = ncdf_pkg::POW_STAGES;

    logic [31:0] r_mean;
    logic [30:0] r_std_dev;

    logic               r_in_v;
    logic [31:0]        r_in_x;
    logic               r_d_v;
    logic [32:0]        r_d_diff;
    ncdf_pkg::t_side    r_m_side;
    logic [32:0]        r_m_mag;

    ncdf_pkg::t_side    r_dv_side [0:ZW-1];
    logic [32:0]        r_dv_rem  [0:ZW-1];
    logic [ZW-1:0]      r_dv_q    [0:ZW-1];

    ncdf_pkg::t_side    r_sq1_side;
    logic [63:0]        r_sq1_pl;
    logic [34:0]        r_sq1_cr;
    logic [ZW-1:0]      r_sq1_z;
    ncdf_pkg::t_side    r_sq2_side;
    logic [KW-1:0]      r_sq2_k;
    logic [31:0]        r_sq2_f;
    logic [ZW-1:0]      r_sq2_z;
    logic [69:0]        n_sq_sum;
    logic [36:0]        n_sq_t;

    ncdf_pkg::t_side    r_ha_side [0:HS-1];
    logic [63:0]        r_ha_n    [0:HS-1];
    logic [63:0]        r_ha_d    [0:HS-1];
    logic [66:0]        r_ha_pn   [1:HS-1];
    logic [66:0]        r_ha_pd   [0:HS-1];
    logic [ZW-1:0]      r_ha_z    [0:HS-1];
    logic [KW-1:0]      r_ha_k    [0:HS-1];
    logic [31:0]        r_ha_f    [0:HS-1];
    ncdf_pkg::t_side    r_hb_side [0:HS-1];
    logic [63:0]        r_hb_n    [0:HS-1];
    logic [63:0]        r_hb_d    [0:HS-1];
    logic [ZW-1:0]      r_hb_z    [0:HS-1];
    logic [KW-1:0]      r_hb_k    [0:HS-1];
    logic [31:0]        r_hb_f    [0:HS-1];

    ncdf_pkg::t_side    r_rt_side [0:RB-1];
    logic [63:0]        r_rt_r    [0:RB-1];
    logic [63:0]        r_rt_d    [0:RB-1];
    ncdf_pkg::t_exp_arg r_rt_arg  [0:RB-1];

    ncdf_pkg::t_side    r_sa_side [0:ST-1];
    logic [31:0]        r_sa_v    [0:ST-1];
    ncdf_pkg::t_exp_arg r_sa_arg  [0:ST-1];
    ncdf_pkg::t_side    r_sb_side [0:ST-1];
    logic [31:0]        r_sb_v    [0:ST-1];
    logic [31:0]        r_sb_qe   [0:ST-1];
    ncdf_pkg::t_exp_arg r_sb_arg  [0:ST-1];
    ncdf_pkg::t_side    r_sc_side [0:ST-1];
    logic [32:0]        r_sc_e    [0:ST-1];
    ncdf_pkg::t_exp_arg r_sc_arg  [0:ST-1];

    ncdf_pkg::t_side    r_pw_side [0:PS-1];
    logic [32:0]        r_pw_e    [0:PS-1];
    ncdf_pkg::t_exp_arg r_pw_arg  [0:PS-1];

    ncdf_pkg::t_side    r_fa_side;
    logic [31:0]        r_fa_prod;
    logic [64:0]        n_fa_prod;
    ncdf_pkg::t_side    r_fb_side;
    logic [31:0]        r_fb_c;
    logic [32:0]        n_fb_round;
    logic [31:0]        n_fb_c;

    logic               r_out_valid;
    logic [31:0]        r_out_prob;

    assign busy          = 1'b0;
    assign o_valid       = r_out_valid;
    assign o_probability = r_out_prob;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean    <= '0;
            r_std_dev <= ncdf_pkg::STD_DEV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ncdf_pkg::CFG_MEAN: begin
                    r_mean <= i_cfg_data;
                end
                ncdf_pkg::CFG_STD_DEV: begin
                    r_std_dev <= i_cfg_data[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front: sample, difference to the mean, magnitude and sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_d_v    <= 1'b0;
            r_m_side <= '0;
        end else begin
            r_in_v        <= start & ~busy;
            r_d_v         <= r_in_v;
            r_m_side.v    <= r_d_v;
            r_m_side.neg  <= r_d_diff[32] | (r_d_diff == '0);
            r_m_side.zero <= (r_std_dev == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_x   <= i_sample;
        r_d_diff <= {r_in_x[31], r_in_x} - {r_mean[31], r_mean};
        r_m_mag  <= r_d_diff[32] ? 33'(-r_d_diff) : r_d_diff;
    end

    // z = mag / sigma, one quotient bit per stage: three integer bits, then
    // thirty-two fraction bits.
    for (genvar s = 0; s < ZW; s++) begin : g_div
        ncdf_pkg::t_side p_side;
        ncdf_pkg::t_side n_side;
        logic [32:0]     p_rem;
        logic [32:0]     n_rem;
        logic [ZW-1:0]   p_q;
        logic            ge;
        logic            kill;

        if (s == 0) begin : g_first
            assign p_side = r_m_side;
            assign p_rem  = r_m_mag;
            assign p_q    = '0;
            // At eight sigma or more the tail is below half an output step.
            assign kill   = {1'b0, r_m_mag} >= {r_std_dev, 3'b000};
        end else begin : g_next
            assign p_side = r_dv_side[s-1];
            assign p_rem  = r_dv_rem[s-1];
            assign p_q    = r_dv_q[s-1];
            assign kill   = 1'b0;
        end

        if (s < ncdf_pkg::Z_INT_BITS) begin : g_int
            logic [33:0] dvs;
            assign dvs   = {3'b000, r_std_dev} << (ncdf_pkg::Z_INT_BITS - 1 - s);
            assign ge    = {1'b0, p_rem} >= dvs;
            assign n_rem = ge ? 33'({1'b0, p_rem} - dvs) : p_rem;
        end else begin : g_frac
            logic [32:0] sh;
            assign sh    = {p_rem[31:0], 1'b0};
            assign ge    = sh >= {2'b00, r_std_dev};
            assign n_rem = ge ? sh - {2'b00, r_std_dev} : sh;
        end

        always_comb begin
            n_side      = p_side;
            n_side.zero = p_side.zero | kill;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_side[s] <= '0;
            end else begin
                r_dv_side[s] <= n_side;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_rem[s] <= n_rem;
            r_dv_q[s]   <= p_q | (ZW'(ge) << (ZW - 1 - s));
        end
    end

    // t = z*z/2, with z split into its integer and fraction parts.
    always_comb begin
        n_sq_sum = {3'b000, r_sq1_z[ZW-1:32]} * {3'b000, r_sq1_z[ZW-1:32]} << 64;
        n_sq_sum = n_sq_sum + {2'b00, r_sq1_cr, 33'b0} + {6'b0, r_sq1_pl};
        n_sq_t   = n_sq_sum[69:33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq1_side <= '0;
            r_sq2_side <= '0;
        end else begin
            r_sq1_side <= r_dv_side[ZW-1];
            r_sq2_side <= '{v:    r_sq1_side.v,
                            neg:  r_sq1_side.neg,
                            zero: r_sq1_side.zero | (n_sq_t >= ncdf_pkg::TAIL_LIMIT)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq1_pl <= 64'(r_dv_q[ZW-1][31:0]) * 64'(r_dv_q[ZW-1][31:0]);
        r_sq1_cr <= 35'(r_dv_q[ZW-1][ZW-1:32]) * 35'(r_dv_q[ZW-1][31:0]);
        r_sq1_z  <= r_dv_q[ZW-1];
        r_sq2_k  <= n_sq_t[36:32];
        r_sq2_f  <= n_sq_t[31:0];
        r_sq2_z  <= r_sq1_z;
    end

    // Horner steps for numerator and denominator. Each step multiplies the
    // low half of the accumulator first, then the high half plus coefficient.
    for (genvar h = 0; h < HS; h++) begin : g_horner
        ncdf_pkg::t_side p_side;
        logic [63:0]     p_n;
        logic [63:0]     p_d;
        logic [ZW-1:0]   p_z;
        logic [KW-1:0]   p_k;
        logic [31:0]     p_f;
        logic [63:0]     n_d;

        if (h == 0) begin : g_first
            assign p_side = r_sq2_side;
            assign p_n    = ncdf_pkg::NUM_COEF[HS-1];
            assign p_d    = ncdf_pkg::DEN_COEF[HS];
            assign p_z    = r_sq2_z;
            assign p_k    = r_sq2_k;
            assign p_f    = r_sq2_f;
        end else begin : g_next
            assign p_side = r_hb_side[h-1];
            assign p_n    = r_hb_n[h-1];
            assign p_d    = r_hb_d[h-1];
            assign p_z    = r_hb_z[h-1];
            assign p_k    = r_hb_k[h-1];
            assign p_f    = r_hb_f[h-1];
        end

        assign n_d = 64'(r_ha_d[h][63:32]) * 64'(r_ha_z[h]) + 64'(r_ha_pd[h][66:32])
                   + ncdf_pkg::DEN_COEF[HS-1-h];

        // The numerator has one degree less, so it waits in the first step.
        if (h == 0) begin : g_num_hold
            always_ff @(posedge i_clk) begin
                r_hb_n[h] <= r_ha_n[h];
            end
        end else begin : g_num_step
            always_ff @(posedge i_clk) begin
                r_ha_pn[h] <= 67'(p_n[31:0]) * 67'(p_z);
                r_hb_n[h]  <= 64'(r_ha_n[h][63:32]) * 64'(r_ha_z[h])
                            + 64'(r_ha_pn[h][66:32]) + ncdf_pkg::NUM_COEF[HS-1-h];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ha_side[h] <= '0;
                r_hb_side[h] <= '0;
            end else begin
                r_ha_side[h] <= p_side;
                r_hb_side[h] <= r_ha_side[h];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ha_n[h]  <= p_n;
            r_ha_d[h]  <= p_d;
            r_ha_pd[h] <= 67'(p_d[31:0]) * 67'(p_z);
            r_ha_z[h]  <= p_z;
            r_ha_k[h]  <= p_k;
            r_ha_f[h]  <= p_f;
            r_hb_d[h]  <= n_d;
            r_hb_z[h]  <= r_ha_z[h];
            r_hb_k[h]  <= r_ha_k[h];
            r_hb_f[h]  <= r_ha_f[h];
        end
    end

    // ratio = floor(n * 2^32 / d), one bit per stage.
    for (genvar s = 0; s < RB; s++) begin : g_ratio
        ncdf_pkg::t_side    p_side;
        logic [63:0]        p_r;
        logic [63:0]        p_d;
        ncdf_pkg::t_exp_arg p_arg;
        ncdf_pkg::t_exp_arg n_arg;
        logic [63:0]        sh;
        logic               ge;

        if (s == 0) begin : g_first
            assign p_side = r_hb_side[HS-1];
            assign p_r    = r_hb_n[HS-1];
            assign p_d    = r_hb_d[HS-1];
            assign p_arg  = ncdf_pkg::t_exp_arg'{k: r_hb_k[HS-1], f: r_hb_f[HS-1],
                                                 ratio: '0};
        end else begin : g_next
            assign p_side = r_rt_side[s-1];
            assign p_r    = r_rt_r[s-1];
            assign p_d    = r_rt_d[s-1];
            assign p_arg  = r_rt_arg[s-1];
        end

        assign sh = {p_r[62:0], 1'b0};
        assign ge = sh >= p_d;

        always_comb begin
            n_arg       = p_arg;
            n_arg.ratio = {p_arg.ratio[30:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_side[s] <= '0;
            end else begin
                r_rt_side[s] <= p_side;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rt_r[s]   <= ge ? sh - p_d : sh;
            r_rt_d[s]   <= p_d;
            r_rt_arg[s] <= n_arg;
        end
    end

    // exp(-f) by the nested series, terms 13 down to 1. Each term takes a
    // product, a reciprocal multiply and a one-step quotient correction.
    for (genvar g = 0; g < ST; g++) begin : g_series
        localparam int          TERM = ST - g;
        localparam logic [35:0] DIVC = 36'(TERM);

        ncdf_pkg::t_side    p_side;
        logic [32:0]        p_e;
        ncdf_pkg::t_exp_arg p_arg;
        logic [64:0]        n_prod;
        logic [65:0]        n_recip;
        logic [35:0]        n_rem;
        logic               ge;

        if (g == 0) begin : g_first
            assign p_side = r_rt_side[RB-1];
            assign p_e    = ncdf_pkg::ONE_Q32;
            assign p_arg  = r_rt_arg[RB-1];
        end else begin : g_next
            assign p_side = r_sc_side[g-1];
            assign p_e    = r_sc_e[g-1];
            assign p_arg  = r_sc_arg[g-1];
        end

        assign n_prod  = 65'(p_arg.f) * 65'(p_e);
        assign n_recip = 66'(r_sa_v[g]) * 66'(ncdf_pkg::SER_RECIP[TERM]);
        // The estimate is at most one short of the true quotient.
        assign n_rem   = 36'(r_sb_v[g]) - 36'(r_sb_qe[g]) * DIVC;
        assign ge      = n_rem >= DIVC;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa_side[g] <= '0;
                r_sb_side[g] <= '0;
                r_sc_side[g] <= '0;
            end else begin
                r_sa_side[g] <= p_side;
                r_sb_side[g] <= r_sa_side[g];
                r_sc_side[g] <= r_sb_side[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sa_v[g]   <= n_prod[63:32];
            r_sa_arg[g] <= p_arg;
            r_sb_v[g]   <= r_sa_v[g];
            r_sb_qe[g]  <= n_recip[64:33];
            r_sb_arg[g] <= r_sa_arg[g];
            r_sc_e[g]   <= ncdf_pkg::ONE_Q32 - 33'(r_sb_qe[g] + 32'(ge));
            r_sc_arg[g] <= r_sb_arg[g];
        end
    end

    // Multiply by exp(-1) once for each whole unit of t.
    for (genvar j = 0; j < PS; j++) begin : g_pow
        localparam logic [KW-1:0] STEP = KW'(j);

        ncdf_pkg::t_side    p_side;
        logic [32:0]        p_e;
        ncdf_pkg::t_exp_arg p_arg;
        logic [64:0]        n_prod;

        if (j == 0) begin : g_first
            assign p_side = r_sc_side[ST-1];
            assign p_e    = r_sc_e[ST-1];
            assign p_arg  = r_sc_arg[ST-1];
        end else begin : g_next
            assign p_side = r_pw_side[j-1];
            assign p_e    = r_pw_e[j-1];
            assign p_arg  = r_pw_arg[j-1];
        end

        assign n_prod = 65'(p_e) * 65'(ncdf_pkg::EXP_M1_Q32);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pw_side[j] <= '0;
            end else begin
                r_pw_side[j] <= p_side;
            end
        end

        always_ff @(posedge i_clk) begin
            r_pw_e[j]   <= (STEP < p_arg.k) ? 33'(n_prod[63:32]) : p_e;
            r_pw_arg[j] <= p_arg;
        end
    end

    // Tail = e * ratio, rounded to Q1.31, then reflected above the mean.
    assign n_fa_prod  = 65'(r_pw_e[PS-1]) * 65'(r_pw_arg[PS-1].ratio);
    assign n_fb_round = 33'(r_fa_prod) + 33'd1;

    always_comb begin
        n_fb_c = n_fb_round[32:1];
        if (r_fa_side.zero) begin
            n_fb_c = '0;
        end else if (n_fb_c > ncdf_pkg::PROB_ONE) begin
            n_fb_c = ncdf_pkg::PROB_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_side   <= '0;
            r_fb_side   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fa_side   <= r_pw_side[PS-1];
            r_fb_side   <= r_fa_side;
            r_out_valid <= r_fb_side.v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fa_prod  <= n_fa_prod[63:32];
        r_fb_c     <= n_fb_c;
        r_out_prob <= r_fb_side.neg ? r_fb_c : ncdf_pkg::PROB_ONE - r_fb_c;
    end

    `NCDF_CHECK_SAME(a_prob_range, r_out_valid, r_out_prob <= ncdf_pkg::PROB_ONE, "probability above one")
    `NCDF_CHECK_SAME(a_series_range, r_sc_side[ST-1].v, (r_sc_e[ST-1] != '0) && (r_sc_e[ST-1] <= ncdf_pkg::ONE_Q32), "series term out of range")
    `NCDF_CHECK_NEXT(a_zero_sigma, r_m_side.v && (r_std_dev == '0), r_dv_side[0].zero, "zero sigma beat not forced to an empty tail")

endmodule
